### rtl/core/sliding_window_mean_variance_unit_macros.svh
// ----------------------------------------------------------------------------
// Sliding window mean/variance assertion macros
// Concurrent assertion wrappers clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEAN_VARIANCE_UNIT_MACROS_SVH
`define SLIDING_WINDOW_MEAN_VARIANCE_UNIT_MACROS_SVH

// same-cycle implication
`define SWMV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SWMV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/swmv_pkg.sv
// ----------------------------------------------------------------------------
// swmv_pkg
// Shared widths and defaults for the sliding window mean/variance unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swmv_pkg;

  localparam int unsigned WindowMaxDef = 64;
  localparam int unsigned SampleW      = 32;
  localparam int unsigned VarW         = 63;
  localparam int unsigned CntW         = 7;
  localparam int unsigned WlW          = 7;
  localparam int unsigned DivW         = 64;
  localparam logic [WlW-1:0] WlReset   = 7'd8;

endpackage

### rtl/core/swmv_div.sv
// ----------------------------------------------------------------------------
// swmv_div
// Restoring unsigned divider, one quotient bit per cycle, small divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swmv_div import swmv_pkg::*; #(
  parameter int unsigned DvsW = 7
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [DvsW-1:0] divisor_i,
  output logic            done_o,
  output logic [DivW-1:0] quot_o
);

  localparam int unsigned CntBits = $clog2(DivW + 1);

  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivW-1:0]    dq_q, dq_d;
  logic [DvsW-1:0]    rem_q, rem_d;
  logic [DvsW-1:0]    dvs_q, dvs_d;
  logic [DvsW:0]      rem_sh;
  logic               ge;

  always_comb begin
    rem_sh = {rem_q, dq_q[DivW-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntBits'(DivW);
      dq_d   = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? DvsW'(rem_sh - {1'b0, dvs_q}) : DvsW'(rem_sh);
      dq_d  = {dq_q[DivW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule

### rtl/core/sliding_window_mean_variance_unit.sv
// Path: a clear or a window below two goes straight to the result; the first sample
//   needs no divide, a filling window runs the mean divide (and the variance divide
//   when it applies), and a full window also runs the removal divide first.
// Flow: one word in flight; every divider pass uses the shared serial divider, and the
//   next word can be taken in the same cycle as the result is presented.
// Reset: window length 8, window empty, statistics zero, no result pending.
// ----------------------------------------------------------------------------
// sliding_window_mean_variance_unit
// Welford mean and sum of squared deviations over a sliding sample window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sliding_window_mean_variance_unit_macros.svh"

module sliding_window_mean_variance_unit import swmv_pkg::*; #(
  parameter int unsigned WindowMax = WindowMaxDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [WlW-1:0]            window_length_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      command_i,
  input  logic signed [SampleW-1:0] sample_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [SampleW-1:0] mean_o,
  output logic [VarW-1:0]           variance_o,
  output logic [CntW-1:0]           count_o
);

  localparam int unsigned CW = $clog2(WindowMax + 1);
  localparam int unsigned AW = $clog2(WindowMax);
  localparam int unsigned NW = SampleW + CW + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_RMUL  = 4'd2;
  localparam logic [3:0] S_RDIV  = 4'd3;
  localparam logic [3:0] S_RWAIT = 4'd4;
  localparam logic [3:0] S_ADD   = 4'd5;
  localparam logic [3:0] S_AWAIT = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_ACC   = 4'd8;
  localparam logic [3:0] S_WR    = 4'd9;
  localparam logic [3:0] S_VAR   = 4'd10;
  localparam logic [3:0] S_VWAIT = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  localparam logic signed [63:0] S64Max = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64Min = {1'b1, {63{1'b0}}};

  function automatic logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64Min : S64Max;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub(logic signed [63:0] a, logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64Min : S64Max;
    return s[63:0];
  endfunction

  logic [3:0]                state_q, state_d;
  logic [WlW-1:0]            wl_q, wl_d;
  logic [CW-1:0]             fill_q, fill_d;
  logic [AW-1:0]             oldest_q, oldest_d;
  logic signed [SampleW-1:0] mean_q, mean_d;
  logic signed [63:0]        dsum_q, dsum_d;
  logic signed [SampleW-1:0] last_q, last_d;
  logic signed [SampleW-1:0] x_q, x_d;
  logic signed [NW-1:0]      num_q, num_d;
  logic signed [SampleW:0]   d1_q, d1_d;
  logic [65:0]               prod_q, prod_d;
  logic                      neg_q, neg_d;
  logic signed [63:0]        inc_q, inc_d;
  logic [VarW-1:0]           var_q, var_d;
  logic                      out_valid_q, out_valid_d;
  logic signed [SampleW-1:0] mean_out_q, mean_out_d;
  logic [VarW-1:0]           var_out_q, var_out_d;
  logic [CntW-1:0]           cnt_out_q, cnt_out_d;

  logic signed [SampleW-1:0] sample_mem_q [WindowMax];
  logic signed [63:0]        inc_mem_q [WindowMax];
  logic signed [SampleW-1:0] old_rd_q;
  logic signed [63:0]        inc_rd_q;
  logic                      mem_re, mem_we;

  logic [CW-1:0]   win;
  logic [CW:0]     slot_sum;
  logic [AW-1:0]   slot;
  logic            in_acc;
  logic            div_start, div_done;
  logic [DivW-1:0] div_dividend, div_quot;
  logic [CW-1:0]   div_divisor;
  logic [NW-1:0]   num_mag;
  logic [SampleW:0] d2, mag1, mag2;
  logic signed [SampleW+1:0] nm;

  assign win = (wl_q == '0) ? CW'(1) :
               (int'(wl_q) > int'(WindowMax)) ? CW'(WindowMax) : CW'(wl_q);
  assign slot_sum = {1'b0, oldest_q} + {1'b0, fill_q};
  assign slot = (slot_sum >= {1'b0, win}) ? AW'(slot_sum - {1'b0, win}) : AW'(slot_sum);
  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign num_mag = num_q[NW-1] ? NW'(-num_q) : NW'(num_q);
  assign d2 = {x_q[SampleW-1], x_q} - {mean_q[SampleW-1], mean_q};
  assign mag1 = d1_q[SampleW] ? (SampleW+1)'(-d1_q) : (SampleW+1)'(d1_q);
  assign mag2 = d2[SampleW] ? (SampleW+1)'(-d2) : d2;
  assign nm = (SampleW+2)'(mean_q) +
              (neg_q ? -$signed({1'b0, div_quot[SampleW:0]})
                     : $signed({1'b0, div_quot[SampleW:0]}));

  swmv_div #(.DvsW(CW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    state_d      = state_q;
    wl_d         = wl_q;
    fill_d       = fill_q;
    oldest_d     = oldest_q;
    mean_d       = mean_q;
    dsum_d       = dsum_q;
    last_d       = last_q;
    x_d          = x_q;
    num_d        = num_q;
    d1_d         = d1_q;
    prod_d       = prod_q;
    neg_d        = neg_q;
    inc_d        = inc_q;
    var_d        = var_q;
    out_valid_d  = out_valid_q && out_stall_i;
    mean_out_d   = mean_out_q;
    var_out_d    = var_out_q;
    cnt_out_d    = cnt_out_q;
    mem_re       = 1'b0;
    mem_we       = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (cfg_we_i) begin
          wl_d     = window_length_i;
          fill_d   = '0;
          oldest_d = '0;
          mean_d   = '0;
          dsum_d   = '0;
          last_d   = '0;
        end else if (in_acc) begin
          var_d = '0;
          if (command_i) begin
            fill_d   = '0;
            oldest_d = '0;
            mean_d   = '0;
            dsum_d   = '0;
            last_d   = '0;
            state_d  = S_FIN;
          end else begin
            last_d = sample_i;
            x_d    = sample_i;
            priority if (win < CW'(2)) begin
              state_d = S_FIN;
            end else if (fill_q >= win) begin
              state_d = S_RD;
            end else begin
              state_d = S_ADD;
            end
          end
        end
      end
      S_RD: begin
        mem_re  = 1'b1;
        state_d = S_RMUL;
      end
      S_RMUL: begin
        num_d   = NW'($signed(mean_q) * $signed({1'b0, fill_q})) - NW'(old_rd_q);
        state_d = S_RDIV;
      end
      S_RDIV: begin
        div_start    = 1'b1;
        div_dividend = DivW'(num_mag);
        div_divisor  = fill_q - 1'b1;
        neg_d        = num_q[NW-1];
        state_d      = S_RWAIT;
      end
      S_RWAIT: begin
        if (div_done) begin
          if (!neg_q) begin
            mean_d = (div_quot > DivW'(S64Max >>> 32)) ? {1'b0, {(SampleW-1){1'b1}}}
                                                      : div_quot[SampleW-1:0];
          end else begin
            mean_d = (div_quot > DivW'(64'h8000_0000)) ? {1'b1, {(SampleW-1){1'b0}}}
                                                      : -div_quot[SampleW-1:0];
          end
          dsum_d   = sat_sub(dsum_q, inc_rd_q);
          oldest_d = ((CW'(oldest_q) + 1'b1) == win) ? '0 : oldest_q + 1'b1;
          fill_d   = fill_q - 1'b1;
          state_d  = S_ADD;
        end
      end
      S_ADD: begin
        if (fill_q == '0) begin
          mean_d  = x_q;
          dsum_d  = '0;
          inc_d   = '0;
          state_d = S_WR;
        end else begin
          d1_d         = {x_q[SampleW-1], x_q} - {mean_q[SampleW-1], mean_q};
          div_start    = 1'b1;
          div_dividend = DivW'(d1_d[SampleW] ? (SampleW+1)'(-d1_d) : (SampleW+1)'(d1_d));
          div_divisor  = fill_q + 1'b1;
          neg_d        = d1_d[SampleW];
          state_d      = S_AWAIT;
        end
      end
      S_AWAIT: begin
        if (div_done) begin
          mean_d  = nm[SampleW-1:0];
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod_d  = 66'(mag1) * 66'(mag2);
        neg_d   = d1_q[SampleW] ^ d2[SampleW];
        state_d = S_ACC;
      end
      S_ACC: begin
        if (|prod_q[65:63]) begin
          inc_d = neg_q ? S64Min : S64Max;
        end else begin
          inc_d = neg_q ? -$signed(prod_q[63:0]) : $signed(prod_q[63:0]);
        end
        dsum_d  = sat_add(dsum_q, inc_d);
        state_d = S_WR;
      end
      S_WR: begin
        mem_we  = 1'b1;
        fill_d  = fill_q + 1'b1;
        state_d = S_VAR;
      end
      S_VAR: begin
        if (fill_q >= CW'(2) && !dsum_q[63] && dsum_q != '0) begin
          div_start    = 1'b1;
          div_dividend = DivW'(dsum_q);
          div_divisor  = fill_q - 1'b1;
          state_d      = S_VWAIT;
        end else begin
          var_d   = '0;
          state_d = S_FIN;
        end
      end
      S_VWAIT: begin
        if (div_done) begin
          var_d   = div_quot[VarW-1:0];
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          mean_out_d  = (win < CW'(2)) ? last_q : mean_q;
          var_out_d   = var_q;
          cnt_out_d   = CntW'(fill_q);
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wl_q        <= WlReset;
      fill_q      <= '0;
      oldest_q    <= '0;
      mean_q      <= '0;
      dsum_q      <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wl_q        <= wl_d;
      fill_q      <= fill_d;
      oldest_q    <= oldest_d;
      mean_q      <= mean_d;
      dsum_q      <= dsum_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    num_q      <= num_d;
    d1_q       <= d1_d;
    prod_q     <= prod_d;
    neg_q      <= neg_d;
    inc_q      <= inc_d;
    var_q      <= var_d;
    mean_out_q <= mean_out_d;
    var_out_q  <= var_out_d;
    cnt_out_q  <= cnt_out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      sample_mem_q[slot] <= x_q;
      inc_mem_q[slot]    <= inc_q;
    end
    if (mem_re) begin
      old_rd_q <= sample_mem_q[oldest_q];
      inc_rd_q <= inc_mem_q[oldest_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign mean_o      = mean_out_q;
  assign variance_o  = var_out_q;
  assign count_o     = cnt_out_q;

  `SWMV_ASSERT_NOW(a_fill_in_window, 1'b1, fill_q <= win, "fill count exceeds window")
  `SWMV_ASSERT_NOW(a_oldest_in_window, 1'b1, CW'(oldest_q) < win, "oldest index out of window")
  `SWMV_ASSERT_NXT(a_busy_after_accept, in_acc && !cfg_we_i, state_q != S_IDLE, "accept not taken")

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sliding window mean/variance unit. A local
// predictor tracks the window, ring contents, mean and sum of squared
// deviations; every output word is compared field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import swmv_pkg::*;

  localparam int unsigned WMAX = WindowMaxDef;
  localparam int unsigned WDOG_LIMIT = 20000;
  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic signed [31:0] mean;
    logic [62:0]        variance;
    logic [6:0]         count;
  } stats_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [WlW-1:0] wl_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic cmd = CMD_ADD;
  logic signed [31:0] smp = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] mean_w;
  logic [62:0] var_w;
  logic [6:0] cnt_w;

  always #2 clk = ~clk;

  sliding_window_mean_variance_unit uut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .window_length_i(wl_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .command_i(cmd), .sample_i(smp),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .mean_o(mean_w),
    .variance_o(var_w), .count_o(cnt_w)
  );

  // predictor state
  logic signed [31:0] win_samples [WMAX];
  logic signed [63:0] win_incs [WMAX];
  int unsigned head_idx, fill, wlen;
  logic signed [31:0] avg, latched;
  logic signed [63:0] dsum;

  stats_t expected_q [$];
  int errors = 0;
  int n_items = 0, n_words = 0;
  int idle_cnt = 0;
  int out_draw = 0;
  bit stall_on = 1'b1;

  localparam logic signed [63:0] S64MAX = 64'sh7FFFFFFFFFFFFFFF;
  localparam logic signed [63:0] S64MIN = 64'sh8000000000000000;

  function automatic logic signed [63:0] add_sat(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) s = a[63] ? S64MIN : S64MAX;
    return s;
  endfunction

  function automatic logic signed [63:0] sub_sat(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [63:0] s;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63]) s = a[63] ? S64MIN : S64MAX;
    return s;
  endfunction

  function automatic logic signed [63:0] prod_sat(logic signed [63:0] a, logic signed [63:0] b);
    logic [63:0] ma, mb;
    logic [127:0] p;
    logic neg;
    neg = a[63] ^ b[63];
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    p = ma * mb;
    p = {64'd0, p[63:0]};
    if (!neg) return (p[63]) ? S64MAX : $signed(p[63:0]);
    if (p[63]) return S64MIN;
    return -$signed(p[63:0]);
  endfunction

  task automatic clear_window();
    for (int i = 0; i < WMAX; i++) begin
      win_samples[i] = '0;
      win_incs[i] = '0;
    end
    head_idx = 0; fill = 0; avg = '0; dsum = '0; latched = '0;
  endtask

  function automatic int unsigned eff_len();
    if (wlen < 1) return 1;
    if (wlen > WMAX) return WMAX;
    return wlen;
  endfunction

  task automatic predict_word(logic c, logic signed [31:0] x);
    int unsigned w, idx, slot;
    logic signed [63:0] n, m, prev, d1, nm, inc;
    stats_t e;
    w = eff_len();
    if (c == CMD_CLEAR) begin
      clear_window();
    end else begin
      latched = x;
      inc = '0;
      if (w >= 2) begin
        if (fill >= w) begin
          idx = head_idx % w;
          n = fill;
          m = (64'(avg) * n - 64'(win_samples[idx])) / (n - 1);
          if (m > 64'sd2147483647) m = 64'sd2147483647;
          if (m < -64'sd2147483648) m = -64'sd2147483648;
          avg = m[31:0];
          dsum = sub_sat(dsum, win_incs[idx]);
          head_idx = (idx + 1) % w;
          fill--;
        end
        if (fill == 0) begin
          avg = x;
          dsum = '0;
        end else begin
          prev = avg;
          d1 = 64'(x) - prev;
          nm = prev + d1 / $signed(64'(fill) + 64'd1);
          avg = nm[31:0];
          inc = prod_sat(d1, 64'(x) - nm);
          dsum = add_sat(dsum, inc);
        end
        slot = (head_idx + fill) % w;
        win_samples[slot] = x;
        win_incs[slot] = inc;
        fill++;
      end
    end
    e.mean = (w < 2) ? latched : avg;
    e.variance = (fill >= 2 && dsum > 0) ? 63'(dsum / (64'(fill) - 1)) : '0;
    e.count = 7'(fill);
    expected_q.push_back(e);
  endtask

  task automatic send_word(logic c, logic signed [31:0] x);
    int gap;
    gap = stall_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd <= c;
    smp <= x;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_word(c, x);
    n_items++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (expected_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
  endtask

  task automatic write_window(logic [6:0] v);
    drain();
    cfg_we <= 1'b1;
    wl_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    wlen = v;
    clear_window();
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      stats_t e;
      n_words++;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected word mean=%h var=%h cnt=%0d", $time, mean_w, var_w, cnt_w);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (e.mean !== mean_w) begin
          $display("%0t mean exp %h got %h", $time, e.mean, mean_w); errors++;
        end
        if (e.variance !== var_w) begin
          $display("%0t variance exp %h got %h", $time, e.variance, var_w); errors++;
        end
        if (e.count !== cnt_w) begin
          $display("%0t count exp %0d got %0d", $time, e.count, cnt_w); errors++;
        end
      end
    end
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        out_draw = $urandom_range(0, 4);
        out_stall <= stall_on && (out_draw != 0);
        idle_cnt <= (out_draw != 0) ? out_draw - 1 : 0;
      end else if (out_valid && out_stall) begin
        if (idle_cnt > 0) idle_cnt <= idle_cnt - 1;
        else out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WDOG_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  function automatic logic signed [31:0] rnd_sample(int mode);
    case (mode)
      0: return $signed($urandom());
      1: return $signed(32'($urandom_range(0, 8191)) - 32'sd4096) <<< 8;
      default: return $signed(32'($urandom_range(0, 200)) - 32'sd100) <<< 16;
    endcase
  endfunction

  task automatic test_directed();
    send_word(CMD_ADD, 32'sh7FFFFFFF);
    send_word(CMD_ADD, 32'sh80000000);
    send_word(CMD_ADD, 32'sh7FFFFFFF);
    send_word(CMD_ADD, 32'sh0);
    send_word(CMD_ADD, 32'shFFFFFFFF);
    for (int i = 0; i < 6; i++) send_word(CMD_ADD, 32'sh00010000 * i);
    send_word(CMD_CLEAR, 32'sh12345678);
    send_word(CMD_ADD, 32'sh00020000);
    send_word(CMD_CLEAR, 32'shFFFFFFFF);
  endtask

  task automatic test_small_windows();
    write_window(7'd0);
    send_word(CMD_ADD, 32'sh80000000);
    send_word(CMD_ADD, 32'sh7FFFFFFF);
    send_word(CMD_CLEAR, 32'sh0);
    write_window(7'd1);
    send_word(CMD_ADD, 32'sh00050000);
    write_window(7'd2);
    for (int i = 0; i < 6; i++) send_word(CMD_ADD, (i % 2) ? 32'sh7FFFFFFF : 32'sh80000000);
    write_window(7'd127);
    for (int i = 0; i < 3; i++) send_word(CMD_ADD, rnd_sample(0));
  endtask

  task automatic test_random_windows();
    int unsigned lens[6] = '{3, 5, 8, 16, 64, 100};
    logic [6:0] v;
    for (int ph = 0; ph < 10; ph++) begin
      v = (ph < 6) ? 7'(lens[ph]) : 7'($urandom_range(0, 127));
      write_window(v);
      for (int k = 0; k < 160; k++) begin
        if ($urandom_range(0, 40) == 0) send_word(CMD_CLEAR, rnd_sample(0));
        else send_word(CMD_ADD, rnd_sample($urandom_range(0, 2)));
        if (k == 80 && ph == 3) drain();
      end
    end
  endtask

  task automatic test_no_idle();
    stall_on = 1'b0;
    write_window(7'd4);
    for (int k = 0; k < 60; k++) send_word(CMD_ADD, rnd_sample(2));
    stall_on = 1'b1;
  endtask

  initial begin
    wlen = WlReset;
    clear_window();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_small_windows();
    test_random_windows();
    test_no_idle();
    drain();
    $display("covered %0d input words and %0d output words over window lengths 0..127",
             n_items, n_words);
    $display("including clears, saturation extremes and full-window removals");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
